### hw/rtl/rk4_harmonic_oscillator_step_unit_assert.svh
// assertion macros for the rk4 oscillator step unit
`ifndef RK4_HARMONIC_OSCILLATOR_STEP_UNIT_ASSERT_SVH
`define RK4_HARMONIC_OSCILLATOR_STEP_UNIT_ASSERT_SVH

// checked only outside reset
`define RK4HO_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RK4HO_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rk4ho_pkg.sv
// shared types, constants and helpers of the rk4 oscillator step unit
`default_nettype none

package rk4ho_pkg;

   localparam int DEF_MAX_POINTS = 65536;
   localparam int DEF_FRAC_BITS  = 24;

   localparam int WIDE_W = 48;
   localparam int ACC_W  = 36;
   localparam int TERM_W = 33;

   // x / 3 == (x * DIV3_MAGIC) >> 33 for every 32-bit x
   localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;

   localparam logic signed [WIDE_W-1:0] S32_MAX_W = 48'sh0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] S32_MIN_W = 48'shFFFF_8000_0000;

   localparam logic [31:0] RST_INIT_POS    = 32'd0;
   localparam logic [31:0] RST_INIT_VEL    = 32'd16777216;
   localparam logic [31:0] RST_START_TIME  = 32'd0;
   localparam logic [24:0] RST_STEP_SIZE   = 25'd167772;
   localparam logic [16:0] RST_POINT_COUNT = 17'd501;

   typedef enum logic [2:0] {
      CSR_INIT_POS    = 3'd0,
      CSR_INIT_VEL    = 3'd1,
      CSR_START_TIME  = 3'd2,
      CSR_STEP_SIZE   = 3'd3,
      CSR_POINT_COUNT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] init_pos;
      logic signed [31:0] init_vel;
      logic signed [31:0] start_time;
      logic [24:0]        step_size;
      logic [16:0]        point_count;
   } cfg_type;

   typedef enum logic [1:0] {
      DEN_ONE,
      DEN_HALF,
      DEN_THIRD,
      DEN_SIXTH
   } den_type;

   typedef enum logic [1:0] {
      PART_COMB_Y,
      PART_COMB_V,
      PART_STAGE_Y,
      PART_STAGE_V
   } part_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADV_INIT,
      ST_ABS,
      ST_MUL,
      ST_RND,
      ST_DIV,
      ST_FIX,
      ST_ACC,
      ST_ADV_DONE,
      ST_TM_MUL,
      ST_TM_SUM,
      ST_FINISH
   } seq_state_type;

   // weight of stage j in the final combination: 1/6, 1/3, 1/3, 1/6
   function automatic den_type comb_den(input logic [1:0] stage);
      den_type d;
      d = (stage == 2'd0 || stage == 2'd3) ? DEN_SIXTH : DEN_THIRD;
      return d;
   endfunction

   // step fraction toward the next stage point: 1/2, 1/2, 1
   function automatic den_type stage_den(input logic [1:0] stage);
      den_type d;
      d = (stage == 2'd2) ? DEN_ONE : DEN_HALF;
      return d;
   endfunction

   function automatic logic signed [WIDE_W-1:0] sx48(input logic signed [31:0] a);
      logic signed [WIDE_W-1:0] r;
      r = {{(WIDE_W-32){a[31]}}, a};
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [31:0] r;
      if (x > S32_MAX_W) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < S32_MIN_W) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rk4ho_mul.sv
// shared registered 32x32 unsigned multiplier
`default_nettype none

module rk4ho_mul (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic [63:0]      p
);

   logic [63:0] p_ff;
   logic [63:0] p_in;

   assign p_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

### hw/rtl/rk4ho_core.sv
// sequencer and datapath of the rk4 step, built around one shared multiplier
`default_nettype none

module rk4ho_core #(
   parameter int MAX_POINTS = rk4ho_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = rk4ho_pkg::DEF_FRAC_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rk4ho_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_restart,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [15:0]            rsp_point_index,
   output logic signed [31:0]     rsp_time_value,
   output logic signed [31:0]     rsp_position,
   output logic signed [31:0]     rsp_velocity,
   output logic                   rsp_is_last
);

   import rk4ho_pkg::*;

   localparam logic [15:0] IDX_CAP =
      (MAX_POINTS - 1 > 65535) ? 16'hFFFF : 16'(MAX_POINTS - 1);
   localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;
   localparam int SH_LO = FRAC_BITS;
   localparam int SH_HI = FRAC_BITS + 1;
   localparam logic [63:0] BIAS_ONE   = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] BIAS_HALF  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] BIAS_THIRD = 64'd3 << (FRAC_BITS - 1);
   localparam logic [63:0] BIAS_SIXTH = 64'd3 << FRAC_BITS;

   seq_state_type state_ff, state_in;

   logic signed [31:0]       y_ff, v_ff, ky_ff, kv_ff, ys_ff, time_ff;
   logic [15:0]              idx_ff;
   logic                     last_ff;
   logic signed [ACC_W-1:0]  acc_y_ff, acc_v_ff;
   logic [31:0]              mag_ff, x_ff;
   logic                     neg_ff;
   logic signed [TERM_W-1:0] term_ff;
   logic [1:0]               stage_ff;
   part_type                 part_ff;

   logic                     rsp_valid_ff;
   logic [15:0]              rsp_index_ff;
   logic signed [31:0]       rsp_time_ff, rsp_pos_ff, rsp_vel_ff;
   logic                     rsp_last_ff;

   logic [31:0]              mul_a, mul_b;
   logic [63:0]              prod;
   logic [31:0]              h_ext, h_eff;
   den_type                  den_cur;
   logic signed [31:0]       k_cur;
   logic                     div3;
   logic [63:0]              rnd_sum;
   logic                     rnd_hi;
   logic [31:0]              q_cur;
   logic [TERM_W-1:0]        q_ext;
   logic                     rsp_load;
   logic                     last_term, last_stage_term;
   logic signed [WIDE_W-1:0] time_sum;

   rk4ho_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   assign h_ext = 32'(cfg.step_size);
   assign h_eff = (h_ext > ONE_FX) ? ONE_FX : h_ext;

   assign den_cur = (part_ff == PART_STAGE_Y || part_ff == PART_STAGE_V) ?
                    stage_den(stage_ff) : comb_den(stage_ff);
   assign k_cur   = (part_ff == PART_COMB_Y || part_ff == PART_STAGE_Y) ? ky_ff : kv_ff;
   assign div3    = (den_cur == DEN_THIRD) || (den_cur == DEN_SIXTH);

   // round to nearest, ties away: add half the divisor, then drop the power of two
   always_comb begin
      unique case (den_cur)
         DEN_ONE:   begin rnd_sum = prod + BIAS_ONE;   rnd_hi = 1'b0; end
         DEN_HALF:  begin rnd_sum = prod + BIAS_HALF;  rnd_hi = 1'b1; end
         DEN_THIRD: begin rnd_sum = prod + BIAS_THIRD; rnd_hi = 1'b0; end
         DEN_SIXTH: begin rnd_sum = prod + BIAS_SIXTH; rnd_hi = 1'b1; end
         default:   begin rnd_sum = prod + BIAS_ONE;   rnd_hi = 1'b0; end
      endcase
   end

   assign q_cur = div3 ? {1'b0, prod[63:33]} : x_ff;
   assign q_ext = {1'b0, q_cur};

   assign last_stage_term = (part_ff == PART_STAGE_V);
   assign last_term       = (stage_ff == 2'd3) && (part_ff == PART_COMB_V);

   assign time_sum = sx48(cfg.start_time) + $signed({1'b0, prod[46:0]});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_restart ? ST_TM_MUL : ST_ADV_INIT;
            end
         end
         ST_ADV_INIT: state_in = ST_ABS;
         ST_ABS:      state_in = ST_MUL;
         ST_MUL:      state_in = ST_RND;
         ST_RND:      state_in = div3 ? ST_DIV : ST_FIX;
         ST_DIV:      state_in = ST_FIX;
         ST_FIX:      state_in = ST_ACC;
         ST_ACC:      state_in = last_term ? ST_ADV_DONE : ST_ABS;
         ST_ADV_DONE: state_in = ST_TM_MUL;
         ST_TM_MUL:   state_in = ST_TM_SUM;
         ST_TM_SUM:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_MUL: begin
            mul_a = mag_ff;
            mul_b = h_eff;
         end
         ST_DIV: begin
            mul_a = x_ff;
            mul_b = DIV3_MAGIC;
         end
         ST_TM_MUL: begin
            mul_a = 32'(idx_ff);
            mul_b = h_eff;
         end
         ST_FINISH: rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         y_ff         <= '0;
         v_ff         <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_restart) begin
                  y_ff   <= cfg.init_pos;
                  v_ff   <= cfg.init_vel;
                  idx_ff <= '0;
               end
            end
            ST_ADV_DONE: begin
               y_ff <= sat32({{(WIDE_W-ACC_W){acc_y_ff[ACC_W-1]}}, acc_y_ff});
               v_ff <= sat32({{(WIDE_W-ACC_W){acc_v_ff[ACC_W-1]}}, acc_v_ff});
               if (idx_ff < IDX_CAP) begin
                  idx_ff <= idx_ff + 16'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_ADV_INIT: begin
            ky_ff    <= v_ff;
            kv_ff    <= sat32(-sx48(y_ff));
            acc_y_ff <= ACC_W'(sx48(y_ff));
            acc_v_ff <= ACC_W'(sx48(v_ff));
            stage_ff <= 2'd0;
            part_ff  <= PART_COMB_Y;
         end
         ST_ABS: begin
            neg_ff <= k_cur[31];
            mag_ff <= k_cur[31] ? 32'(-k_cur) : 32'(k_cur);
         end
         ST_RND: begin
            x_ff <= rnd_hi ? rnd_sum[SH_HI +: 32] : rnd_sum[SH_LO +: 32];
         end
         ST_FIX: begin
            term_ff <= neg_ff ? -$signed(q_ext) : $signed(q_ext);
         end
         ST_ACC: begin
            unique case (part_ff)
               PART_COMB_Y: acc_y_ff <= acc_y_ff + ACC_W'(term_ff);
               PART_COMB_V: acc_v_ff <= acc_v_ff + ACC_W'(term_ff);
               PART_STAGE_Y: ys_ff <= sat32(sx48(y_ff) + WIDE_W'(term_ff));
               PART_STAGE_V: begin
                  ky_ff <= sat32(sx48(v_ff) + WIDE_W'(term_ff));
                  kv_ff <= sat32(-sx48(ys_ff));
               end
               default: begin
               end
            endcase
            if (last_stage_term) begin
               stage_ff <= stage_ff + 2'd1;
               part_ff  <= PART_COMB_Y;
            end else begin
               part_ff  <= part_type'(part_ff + 2'd1);
            end
         end
         ST_TM_SUM: begin
            time_ff <= sat32(time_sum);
            last_ff <= ({1'b0, idx_ff} + 17'd1) == cfg.point_count;
         end
         default: begin
         end
      endcase
   end

   // result register, holds one finished transaction
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= idx_ff;
         rsp_time_ff  <= time_ff;
         rsp_pos_ff   <= y_ff;
         rsp_vel_ff   <= v_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_time_value  = rsp_time_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_velocity    = rsp_vel_ff;
   assign rsp_is_last     = rsp_last_ff;

endmodule

`default_nettype wire

### hw/rtl/rk4_harmonic_oscillator_step_unit.sv
// Fixed-point RK4 step unit for y' = v, v' = -y (Q8.24 by default). A restart
// transaction reloads the configured initial point and returns it as index 0.
// An advance transaction runs the four RK4 stages and returns the new point;
// the single 32x32 multiplier serially forms 14 rounded terms (the eight 1/3
// and 1/6 terms take a second pass for the reciprocal divide by 3) and the
// time product. Input is not ready while an item is in work; one finished
// result can wait in the output register while the next item runs.
// Configuration registers are written through the csr channel, which is
// always ready; indexes beyond the register list are ignored.
`default_nettype none
`include "rk4_harmonic_oscillator_step_unit_assert.svh"

module rk4_harmonic_oscillator_step_unit #(
   parameter int MAX_POINTS = rk4ho_pkg::DEF_MAX_POINTS,
   parameter int FRAC_BITS  = rk4ho_pkg::DEF_FRAC_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_restart,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [15:0]        rsp_point_index,
   output logic signed [31:0] rsp_time_value,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic               rsp_is_last,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_wdata
);

   import rk4ho_pkg::*;

   localparam logic [15:0] IDX_CAP =
      (MAX_POINTS - 1 > 65535) ? 16'hFFFF : 16'(MAX_POINTS - 1);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_pos    <= RST_INIT_POS;
         cfg_ff.init_vel    <= RST_INIT_VEL;
         cfg_ff.start_time  <= RST_START_TIME;
         cfg_ff.step_size   <= RST_STEP_SIZE;
         cfg_ff.point_count <= RST_POINT_COUNT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INIT_POS:    cfg_ff.init_pos    <= csr_wdata;
            CSR_INIT_VEL:    cfg_ff.init_vel    <= csr_wdata;
            CSR_START_TIME:  cfg_ff.start_time  <= csr_wdata;
            CSR_STEP_SIZE:   cfg_ff.step_size   <= csr_wdata[24:0];
            CSR_POINT_COUNT: cfg_ff.point_count <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   rk4ho_core #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_time_value  (rsp_time_value),
      .rsp_position    (rsp_position),
      .rsp_velocity    (rsp_velocity),
      .rsp_is_last     (rsp_is_last)
   );

   // the sequencer is busy right after taking a transaction
   `RK4HO_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "input still ready after accept")
   `RK4HO_ASSERT(a_index_capped, clock, reset, rsp_valid |-> rsp_point_index <= IDX_CAP, "point index above cap")
   `RK4HO_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

`default_nettype wire

### bench/tb_top.sv
// self-checking testbench for the rk4 harmonic oscillator step unit
`timescale 1ns / 100ps

module tb_top;
   import rk4ho_pkg::*;

   localparam int FRAC = 24;
   localparam longint S32_HI = 64'sd2147483647;
   localparam longint S32_LO = -64'sd2147483648;
   localparam longint unsigned ONE_STEP = 64'd1 << FRAC;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 50;

   typedef struct packed {
      logic [15:0]        index;
      logic signed [31:0] time_value;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic               is_last;
   } point_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_ITEM,
      ROW_CHECKED
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   reg_index;
      logic [31:0]  value;
      point_type    gold;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   wire req_ready;
   wire rsp_valid;
   wire [15:0] rsp_point_index;
   wire signed [31:0] rsp_time_value;
   wire signed [31:0] rsp_position;
   wire signed [31:0] rsp_velocity;
   wire rsp_is_last;
   wire csr_ready;

   // oscillator state and register copy kept by the bench
   cfg_type osc_cfg;
   longint osc_pos = 0;
   longint osc_vel = 0;
   logic [15:0] osc_index = '0;

   point_type pending_points[$];
   stim_row_type directed_rows[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit steady = 1'b0;
   bit hold_off_pending = 1'b0;

   rk4_harmonic_oscillator_step_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_index (rsp_point_index),
      .rsp_time_value  (rsp_time_value),
      .rsp_position    (rsp_position),
      .rsp_velocity    (rsp_velocity),
      .rsp_is_last     (rsp_is_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(input longint x);
      if (x > S32_HI) return S32_HI;
      if (x < S32_LO) return S32_LO;
      return x;
   endfunction

   // k * h / (den * 2^FRAC), rounded to nearest with ties away from zero
   function automatic longint scaled_term(input longint k, input longint unsigned h,
                                          input longint unsigned den);
      longint unsigned mag, d, q;
      mag = (k < 0) ? -k : k;
      d = den << FRAC;
      q = (mag * h + d / 2) / d;
      return (k < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic point_type integrate_point(input bit restart);
      longint unsigned h;
      longint y, v, ys, vs, ay, av;
      longint ky[4], kv[4];
      int j;
      point_type p;
      h = (osc_cfg.step_size > ONE_STEP) ? ONE_STEP : osc_cfg.step_size;
      if (restart) begin
         osc_pos = longint'(osc_cfg.init_pos);
         osc_vel = longint'(osc_cfg.init_vel);
         osc_index = '0;
      end else begin
         y = osc_pos;
         v = osc_vel;
         ky[0] = v;
         kv[0] = clamp32(-y);
         // stage points at h/2, h/2, h
         for (j = 1; j < 4; j++) begin
            ys = clamp32(y + scaled_term(ky[j-1], h, (j == 3) ? 64'd1 : 64'd2));
            vs = clamp32(v + scaled_term(kv[j-1], h, (j == 3) ? 64'd1 : 64'd2));
            ky[j] = vs;
            kv[j] = clamp32(-ys);
         end
         ay = y;
         av = v;
         for (j = 0; j < 4; j++) begin
            ay += scaled_term(ky[j], h, (j == 0 || j == 3) ? 64'd6 : 64'd3);
            av += scaled_term(kv[j], h, (j == 0 || j == 3) ? 64'd6 : 64'd3);
         end
         osc_pos = clamp32(ay);
         osc_vel = clamp32(av);
         if (osc_index != 16'hFFFF) osc_index++;
      end
      p.index = osc_index;
      p.time_value = 32'(clamp32(longint'(osc_cfg.start_time) +
                                 longint'(osc_index) * longint'(h)));
      p.position = 32'(osc_pos);
      p.velocity = 32'(osc_vel);
      p.is_last = (osc_cfg.point_count != 0) &&
                  (int'(osc_index) == int'(osc_cfg.point_count) - 1);
      return p;
   endfunction

   function automatic logic [31:0] pick_state();
      logic [31:0] r;
      case ($urandom_range(0, 9))
         0: r = 32'h7FFF_FFFF;
         1: r = 32'h8000_0000;
         2: r = $urandom();
         default: r = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      endcase
      return r;
   endfunction

   function automatic void add_write(input logic [2:0] idx, input logic [31:0] val);
      stim_row_type row;
      row.kind = ROW_WRITE;
      row.reg_index = idx;
      row.value = val;
      row.gold = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input bit restart);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.reg_index = '0;
      row.value = {31'd0, restart};
      row.gold = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input bit restart, input logic [15:0] idx,
                                       input logic [31:0] t, input logic [31:0] y,
                                       input logic [31:0] v, input logic last);
      stim_row_type row;
      row.kind = ROW_CHECKED;
      row.reg_index = '0;
      row.value = {31'd0, restart};
      row.gold = {idx, t, y, v, last};
      directed_rows.push_back(row);
   endfunction

   // waits for the unit to go idle, then writes one register
   task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
      bit taken;
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do begin
         @(posedge clock);
         taken = csr_ready;
         if (taken) begin
            case (idx)
               CSR_INIT_POS:    osc_cfg.init_pos = val;
               CSR_INIT_VEL:    osc_cfg.init_vel = val;
               CSR_START_TIME:  osc_cfg.start_time = val;
               CSR_STEP_SIZE:   osc_cfg.step_size = val[24:0];
               CSR_POINT_COUNT: osc_cfg.point_count = val[16:0];
               default: ;
            endcase
         end
         @(negedge clock);
      end while (!taken);
   endtask

   task automatic offer_item(input bit restart, input bit typed, input point_type gold);
      bit taken;
      point_type want;
      csr_valid <= 1'b0;
      if (!steady && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < 32);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do begin
         @(posedge clock);
         taken = req_ready;
         if (taken) begin
            want = integrate_point(restart);
            pending_points.push_back(typed ? gold : want);
         end
         @(negedge clock);
      end while (!taken);
   endtask

   initial begin : stimulus
      point_type none;
      logic [31:0] val;
      int phase, n;
      none = '0;
      osc_cfg.init_pos = RST_INIT_POS;
      osc_cfg.init_vel = RST_INIT_VEL;
      osc_cfg.start_time = RST_START_TIME;
      osc_cfg.step_size = RST_STEP_SIZE;
      osc_cfg.point_count = RST_POINT_COUNT;

      // advance straight out of reset integrates from the zero state
      add_checked(1'b0, 16'd1, 32'd167772, 32'd0, 32'd0, 1'b0);
      add_checked(1'b1, 16'd0, 32'd0, 32'd0, 32'h0100_0000, 1'b0);
      add_item(1'b0);
      add_item(1'b0);
      add_write(CSR_POINT_COUNT, 32'd1);
      add_checked(1'b1, 16'd0, 32'd0, 32'd0, 32'h0100_0000, 1'b1);
      add_item(1'b0);
      // zero count never flags the last point
      add_write(CSR_POINT_COUNT, 32'd0);
      add_checked(1'b1, 16'd0, 32'd0, 32'd0, 32'h0100_0000, 1'b0);
      add_write(CSR_POINT_COUNT, 32'h0001_FFFF);
      add_item(1'b0);
      // positive extremes, step above 1.0 clipped, time saturates
      add_write(CSR_INIT_POS, 32'h7FFF_FFFF);
      add_write(CSR_INIT_VEL, 32'h7FFF_FFFF);
      add_write(CSR_START_TIME, 32'h7FFF_FFF0);
      add_write(CSR_STEP_SIZE, 32'h01FF_FFFF);
      add_write(CSR_POINT_COUNT, 32'h0001_0000);
      add_checked(1'b1, 16'd0, 32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      add_item(1'b0);
      add_item(1'b0);
      add_item(1'b0);
      // negative extremes with zero step hold still
      add_write(CSR_INIT_POS, 32'h8000_0000);
      add_write(CSR_INIT_VEL, 32'h8000_0000);
      add_write(CSR_START_TIME, 32'h8000_0000);
      add_write(CSR_STEP_SIZE, 32'd0);
      add_checked(1'b1, 16'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_checked(1'b0, 16'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_write(CSR_INIT_POS, 32'h0100_0000);
      add_write(CSR_INIT_VEL, 32'd0);
      add_write(CSR_START_TIME, 32'd0);
      add_write(CSR_STEP_SIZE, 32'h0100_0000);
      add_write(CSR_POINT_COUNT, 32'd3);
      add_item(1'b1);
      add_item(1'b0);
      add_item(1'b0);
      add_item(1'b0);
      add_write(CSR_STEP_SIZE, 32'h0100_0001);
      add_item(1'b0);
      add_write(CSR_INIT_POS, 32'hFF00_0000);
      add_write(CSR_INIT_VEL, 32'hFFC0_0000);
      add_item(1'b1);
      add_item(1'b0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            apply_reg(directed_rows[i].reg_index, directed_rows[i].value);
         end else begin
            offer_item(directed_rows[i].value[0], directed_rows[i].kind == ROW_CHECKED,
                       directed_rows[i].gold);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         steady = (phase == 1);
         apply_reg(CSR_INIT_POS, pick_state());
         apply_reg(CSR_INIT_VEL, pick_state());
         if ($urandom_range(0, 1) != 0) apply_reg(CSR_START_TIME, pick_state());
         case ($urandom_range(0, 7))
            0: val = 32'd0;
            1: val = 32'h0100_0000;
            2: val = $urandom();
            3: val = 32'h01FF_FFFF;
            default: val = $urandom_range(1, 32'h0020_0000);
         endcase
         apply_reg(CSR_STEP_SIZE, val);
         case ($urandom_range(0, 7))
            0: val = 32'd0;
            1: val = 32'd1;
            2: val = $urandom();
            3: val = 32'h0001_0000;
            default: val = $urandom_range(2, 40);
         endcase
         apply_reg(CSR_POINT_COUNT, val);
         // writes past the register list must be ignored
         if ($urandom_range(0, 3) == 0) apply_reg(3'($urandom_range(5, 7)), $urandom());
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == 5) hold_off_pending = 1'b1;
            if (n == 0) begin
               offer_item($urandom_range(0, 3) != 0, 1'b0, none);
            end else begin
               offer_item($urandom_range(0, 11) == 0, 1'b0, none);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // result side backpressure, with one long hold-off on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= 32);
      end
   end

   always @(posedge clock) begin : result_check
      point_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_point_index, rsp_time_value, rsp_position, rsp_velocity, rsp_is_last};
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("point %0d returned with no transaction pending", got.index);
            end
         end else begin
            want = pending_points.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("point mismatch: expected idx %0d t %h y %h v %h last %b",
                           want.index, want.time_value, want.position, want.velocity,
                           want.is_last);
                  $display("                got      idx %0d t %h y %h v %h last %b",
                           got.index, got.time_value, got.position, got.velocity,
                           got.is_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
